// ===== rtl/core/conv2d_pkg.sv =====
// ----------------------------------------------------------------------------
// conv2d_pkg
// Shared widths and codes for the full 2-D convolution block.
// ----------------------------------------------------------------------------
package conv2d_pkg;

  // field widths
  localparam int IdxW    = 6;   // row_index / col_index
  localparam int ValW    = 16;  // Q1.15 sample or coefficient
  localparam int ProdW   = 32;  // Q2.30 product
  localparam int ResW    = 40;  // Q10.30 sum
  localparam int DSizeW  = 6;   // data_rows / data_cols
  localparam int KSizeW  = 4;   // kernel_rows / kernel_cols
  localparam int CfgW    = 6;   // widest register
  localparam int CfgIdxW = 2;

  // input op codes
  localparam logic [1:0] OP_LOAD_KERNEL = 2'd0;
  localparam logic [1:0] OP_LOAD_DATA   = 2'd1;
  localparam logic [1:0] OP_READ        = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NO_KERNEL = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_DATA_ROWS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DATA_COLS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_ROWS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_COLS = 2'd3;

endpackage

// ===== rtl/core/conv2d_full_matrix.sv =====
// ----------------------------------------------------------------------------
// conv2d_full_matrix
// Full 2-D linear convolution served one output element per read request.
// ----------------------------------------------------------------------------
// A load is written into its RAM at the transfer edge and the block stays
// ready for the next item. A read walks every kernel tap through one shared
// multiply-accumulate fed by the two RAM read ports, then waits for the
// product pipeline to drain and the output slot to free up before its result
// is registered; no new item is taken until then. Out-of-range and no-kernel
// reads skip the tap walk and answer with a zero sum.
// After reset a clearing pass zeroes both RAMs; no input is taken during it,
// config writes are.
// ----------------------------------------------------------------------------
module conv2d_full_matrix #(
  parameter int MAX_DATA_ROWS   = 32,
  parameter int MAX_DATA_COLS   = 32,
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [conv2d_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [conv2d_pkg::CfgW-1:0]          cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           op_i,
  input  logic [conv2d_pkg::IdxW-1:0]          row_index_i,
  input  logic [conv2d_pkg::IdxW-1:0]          col_index_i,
  input  logic signed [conv2d_pkg::ValW-1:0]   sample_value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [conv2d_pkg::ResW-1:0]   result_value_o,
  output logic [1:0]                           status_o
);

  // --------------------------------------------------------------------------
  // Storage geometry. Kernel entry is row*MAX_KERNEL_COLS+col, data entry is
  // row*MAX_DATA_COLS+col.
  // --------------------------------------------------------------------------
  localparam int KernelDepth = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int DataDepth   = MAX_DATA_ROWS * MAX_DATA_COLS;
  localparam int KAddrW      = (KernelDepth > 1) ? $clog2(KernelDepth) : 1;
  localparam int DAddrW      = (DataDepth > 1) ? $clog2(DataDepth) : 1;
  localparam int ClrDepth    = (KernelDepth > DataDepth) ? KernelDepth : DataDepth;
  localparam int ClrW        = (ClrDepth > 1) ? $clog2(ClrDepth) : 1;

  localparam int IdxW   = conv2d_pkg::IdxW;
  localparam int ValW   = conv2d_pkg::ValW;
  localparam int ProdW  = conv2d_pkg::ProdW;
  localparam int ResW   = conv2d_pkg::ResW;
  localparam int DSizeW = conv2d_pkg::DSizeW;
  localparam int KSizeW = conv2d_pkg::KSizeW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // --------------------------------------------------------------------------
  // Size registers. Zero acts as one, anything above the maximum as the
  // maximum, so the clamped value is what gets stored.
  // --------------------------------------------------------------------------
  function automatic logic [DSizeW-1:0] clamp_dsize(input logic [DSizeW-1:0] v,
                                                    input int maxv);
    if (v == '0) return DSizeW'(1);
    if (int'(v) > maxv) return DSizeW'(maxv);
    return v;
  endfunction

  function automatic logic [KSizeW-1:0] clamp_ksize(input logic [KSizeW-1:0] v,
                                                    input int maxv);
    if (v == '0) return KSizeW'(1);
    if (int'(v) > maxv) return KSizeW'(maxv);
    return v;
  endfunction

  logic [DSizeW-1:0] data_rows_q, data_cols_q;
  logic [KSizeW-1:0] kernel_rows_q, kernel_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_rows_q   <= DSizeW'(1);
      data_cols_q   <= DSizeW'(1);
      kernel_rows_q <= KSizeW'(1);
      kernel_cols_q <= KSizeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        conv2d_pkg::REG_DATA_ROWS:
          data_rows_q <= clamp_dsize(cfg_data_i[DSizeW-1:0], MAX_DATA_ROWS);
        conv2d_pkg::REG_DATA_COLS:
          data_cols_q <= clamp_dsize(cfg_data_i[DSizeW-1:0], MAX_DATA_COLS);
        conv2d_pkg::REG_KERNEL_ROWS:
          kernel_rows_q <= clamp_ksize(cfg_data_i[KSizeW-1:0], MAX_KERNEL_ROWS);
        conv2d_pkg::REG_KERNEL_COLS:
          kernel_cols_q <= clamp_ksize(cfg_data_i[KSizeW-1:0], MAX_KERNEL_COLS);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control and datapath state
  // --------------------------------------------------------------------------
  state_e                state_q;
  logic [ClrW-1:0]       clr_q;       // clearing pass pointer
  logic                  kernel_loaded_q;
  logic [IdxW-1:0]       r_q, c_q;    // requested output coordinates
  logic [KSizeW-1:0]     i_q, j_q;    // kernel position being issued
  logic                  s1_vld_q;    // RAM read data in flight
  logic                  s1_use_q;    // that term overlaps the data
  logic                  s2_vld_q;    // product register holds a term
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ResW-1:0]  acc_q;
  logic [1:0]            status_q;
  logic                  out_valid_q;
  logic signed [ResW-1:0]  result_q;
  logic [1:0]            out_status_q;

  logic                  in_xfer;
  logic                  ld_kernel_ok, ld_data_ok, rd_range_bad;
  logic [IdxW:0]         out_rows, out_cols;
  logic [IdxW-1:0]       dr, dc;
  logic                  term_ok, last_term;
  logic                  clearing;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign clearing   = (state_q == ST_CLEAR);

  assign ld_kernel_ok = (row_index_i < IdxW'(kernel_rows_q)) &&
                        (col_index_i < IdxW'(kernel_cols_q));
  assign ld_data_ok   = (row_index_i < IdxW'(data_rows_q)) &&
                        (col_index_i < IdxW'(data_cols_q));

  // output size is data + kernel - 1 in each dimension
  assign out_rows = (IdxW+1)'(data_rows_q) + (IdxW+1)'(kernel_rows_q) - (IdxW+1)'(1);
  assign out_cols = (IdxW+1)'(data_cols_q) + (IdxW+1)'(kernel_cols_q) - (IdxW+1)'(1);
  assign rd_range_bad = ((IdxW+1)'(row_index_i) >= out_rows) ||
                        ((IdxW+1)'(col_index_i) >= out_cols);

  // Data element under kernel tap (i,j); terms hanging off the data edges
  // still pass through the pipeline but add zero.
  assign dr = r_q - IdxW'(i_q);
  assign dc = c_q - IdxW'(j_q);
  assign term_ok = (IdxW'(i_q) <= r_q) && (dr < data_rows_q) &&
                   (IdxW'(j_q) <= c_q) && (dc < data_cols_q);
  assign last_term = (i_q == kernel_rows_q - KSizeW'(1)) &&
                     (j_q == kernel_cols_q - KSizeW'(1));

  // --------------------------------------------------------------------------
  // RAM ports: writes come from the clearing pass or from load transfers,
  // reads from the tap walk.
  // --------------------------------------------------------------------------
  logic              k_we, d_we;
  logic [KAddrW-1:0] k_waddr, k_raddr;
  logic [DAddrW-1:0] d_waddr, d_raddr;
  logic [ValW-1:0]   k_wdata, d_wdata, k_rdata, d_rdata;

  assign k_we = (clearing && (int'(clr_q) < KernelDepth)) ||
                (in_xfer && (op_i == conv2d_pkg::OP_LOAD_KERNEL) && ld_kernel_ok);
  assign d_we = (clearing && (int'(clr_q) < DataDepth)) ||
                (in_xfer && (op_i == conv2d_pkg::OP_LOAD_DATA) && ld_data_ok);

  assign k_waddr = clearing ? clr_q[KAddrW-1:0]
                 : KAddrW'(int'(row_index_i) * MAX_KERNEL_COLS + int'(col_index_i));
  assign d_waddr = clearing ? clr_q[DAddrW-1:0]
                 : DAddrW'(int'(row_index_i) * MAX_DATA_COLS + int'(col_index_i));
  assign k_wdata = clearing ? '0 : sample_value_i;
  assign d_wdata = clearing ? '0 : sample_value_i;

  assign k_raddr = KAddrW'(int'(i_q) * MAX_KERNEL_COLS + int'(j_q));
  assign d_raddr = term_ok ? DAddrW'(int'(dr) * MAX_DATA_COLS + int'(dc)) : '0;

  conv2d_ram #(
    .WIDTH (ValW),
    .DEPTH (KernelDepth)
  ) u_kernel_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  conv2d_ram #(
    .WIDTH (ValW),
    .DEPTH (DataDepth)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // Multiply stage: one Q1.15 x Q1.15 product per cycle, zero for terms
  // outside the data. Both factors are sign-extended to the product width.
  assign prod_d = s1_use_q ? (ProdW'($signed(k_rdata)) * ProdW'($signed(d_rdata)))
                           : ProdW'(0);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // --------------------------------------------------------------------------
  // Sequencer: clearing pass, item decode, tap walk, result hand-off.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      kernel_loaded_q <= 1'b0;
      r_q             <= '0;
      c_q             <= '0;
      i_q             <= '0;
      j_q             <= '0;
      s1_vld_q        <= 1'b0;
      s1_use_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      acc_q           <= '0;
      status_q        <= conv2d_pkg::STATUS_OK;
      out_valid_q     <= 1'b0;
      result_q        <= '0;
      out_status_q    <= conv2d_pkg::STATUS_OK;
    end else begin
      // pipeline defaults
      s1_vld_q <= 1'b0;
      s1_use_q <= 1'b0;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        acc_q <= acc_q + ResW'(prod_q);
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ClrW'(1);
          if (clr_q == ClrW'(ClrDepth - 1)) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_xfer) begin
            unique case (op_i)
              conv2d_pkg::OP_LOAD_KERNEL: begin
                if (ld_kernel_ok) begin
                  kernel_loaded_q <= 1'b1;
                end
              end
              conv2d_pkg::OP_LOAD_DATA: ;  // RAM write only
              conv2d_pkg::OP_READ: begin
                r_q   <= row_index_i;
                c_q   <= col_index_i;
                i_q   <= '0;
                j_q   <= '0;
                acc_q <= '0;
                if (rd_range_bad) begin
                  status_q <= conv2d_pkg::STATUS_RANGE;
                  state_q  <= ST_FINISH;
                end else if (!kernel_loaded_q) begin
                  status_q <= conv2d_pkg::STATUS_NO_KERNEL;
                  state_q  <= ST_FINISH;
                end else begin
                  status_q <= conv2d_pkg::STATUS_OK;
                  state_q  <= ST_RUN;
                end
              end
              default: ;  // unused op code
            endcase
          end
        end

        ST_RUN: begin
          s1_vld_q <= 1'b1;
          s1_use_q <= term_ok;
          if (j_q == kernel_cols_q - KSizeW'(1)) begin
            j_q <= '0;
            i_q <= i_q + KSizeW'(1);
          end else begin
            j_q <= j_q + KSizeW'(1);
          end
          if (last_term) begin
            state_q <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // wait for the last product to land and for the output slot
          if (!s1_vld_q && !s2_vld_q && (!out_valid_q || out_ready_i)) begin
            out_valid_q  <= 1'b1;
            result_q     <= acc_q;
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // product pipeline only runs while a read is being summed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (state_q == ST_RUN || state_q == ST_FINISH))
    else $error("product pipeline active outside a read");

  // a new item never enters with partial products still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (!s1_vld_q && !s2_vld_q))
    else $error("item accepted while pipeline busy");

  // error statuses carry a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != conv2d_pkg::STATUS_OK) |-> (result_value_o == '0))
    else $error("non-zero value with error status");

  // a good result needs a kernel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == conv2d_pkg::STATUS_OK) |-> kernel_loaded_q)
    else $error("ok status without a kernel loaded");

endmodule

// ===== rtl/core/conv2d_ram.sv =====
// ----------------------------------------------------------------------------
// conv2d_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module conv2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/conv2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_checker
// Passive scoreboard for conv2d_full_matrix: mirrors the size registers and
// both the kernel and data stores, predicts status and Q10.30 sum for every read
// request, and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module conv2d_checker #(
  parameter int MAX_DATA_ROWS   = 32,
  parameter int MAX_DATA_COLS   = 32,
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [conv2d_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [conv2d_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         op_i,
  input  logic [conv2d_pkg::IdxW-1:0]        row_index_i,
  input  logic [conv2d_pkg::IdxW-1:0]        col_index_i,
  input  logic signed [conv2d_pkg::ValW-1:0] sample_value_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [conv2d_pkg::ResW-1:0] result_value_i,
  input  logic [1:0]                         status_i,
  output int unsigned                        pending_reads_o,
  output int unsigned                        mismatch_count_o
);
  import conv2d_pkg::*;

  localparam int KernelDepth = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
  localparam int DataDepth   = MAX_DATA_ROWS * MAX_DATA_COLS;

  typedef struct packed {
    logic signed [ResW-1:0] value;
    logic [1:0]             status;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
  } conv_point_t;

  conv_point_t            conv_points_q[$];
  logic signed [ValW-1:0] coef_mem   [KernelDepth];
  logic signed [ValW-1:0] sample_mem [DataDepth];
  logic                   kernel_written;
  int                     data_rows, data_cols, kernel_rows, kernel_cols;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic int clamp_size(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic logic signed [ResW-1:0] conv_sum_at(input int r, input int c);
    longint acc;
    int     i, j, dr, dc;
    acc = 0;
    for (i = 0; i < kernel_rows; i++) begin
      for (j = 0; j < kernel_cols; j++) begin
        dr = r - i;
        dc = c - j;
        if (dr >= 0 && dr < data_rows && dc >= 0 && dc < data_cols) begin
          acc += longint'(coef_mem[i * MAX_KERNEL_COLS + j]) *
                 longint'(sample_mem[dr * MAX_DATA_COLS + dc]);
        end
      end
    end
    return acc[ResW-1:0];
  endfunction

  // range check wins over the missing-kernel check
  function automatic conv_point_t predict_read(input int r, input int c);
    conv_point_t p;
    p.row    = r[IdxW-1:0];
    p.col    = c[IdxW-1:0];
    p.value  = '0;
    p.status = STATUS_OK;
    if (r >= data_rows + kernel_rows - 1 || c >= data_cols + kernel_cols - 1) begin
      p.status = STATUS_RANGE;
    end else if (!kernel_written) begin
      p.status = STATUS_NO_KERNEL;
    end else begin
      p.value = conv_sum_at(r, c);
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    conv_point_t want;
    int          errs;
    int          r, c;
    if (!rst_ni) begin
      foreach (coef_mem[k]) coef_mem[k] = '0;
      foreach (sample_mem[k]) sample_mem[k] = '0;
      conv_points_q.delete();
      kernel_written   = 1'b0;
      data_rows        = 1;
      data_cols        = 1;
      kernel_rows      = 1;
      kernel_cols      = 1;
      pending_reads_o  <= 0;
      mismatch_count_o <= 0;
    end else begin
      errs = 0;
      r    = int'(row_index_i);
      c    = int'(col_index_i);

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DATA_ROWS:
            data_rows = clamp_size(int'(cfg_data_i[DSizeW-1:0]), MAX_DATA_ROWS);
          REG_DATA_COLS:
            data_cols = clamp_size(int'(cfg_data_i[DSizeW-1:0]), MAX_DATA_COLS);
          REG_KERNEL_ROWS:
            kernel_rows = clamp_size(int'(cfg_data_i[KSizeW-1:0]), MAX_KERNEL_ROWS);
          REG_KERNEL_COLS:
            kernel_cols = clamp_size(int'(cfg_data_i[KSizeW-1:0]), MAX_KERNEL_COLS);
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (conv_points_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %0d status %0d",
                   $time, result_value_i, status_i);
          errs++;
        end else begin
          want = conv_points_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status at (%0d,%0d): expected %0d, got %0d",
                     $time, want.row, want.col, want.status, status_i);
            errs++;
          end
          if (result_value_i !== want.value) begin
            $display("%0t: sum at (%0d,%0d): expected %0d, got %0d",
                     $time, want.row, want.col, want.value, result_value_i);
            errs++;
          end
        end
      end

      // loads outside the current sizes leave everything untouched
      if (in_valid_i && in_ready_i) begin
        case (op_i)
          OP_LOAD_KERNEL: begin
            if (r < kernel_rows && c < kernel_cols) begin
              coef_mem[r * MAX_KERNEL_COLS + c] = sample_value_i;
              kernel_written = 1'b1;
            end
          end
          OP_LOAD_DATA: begin
            if (r < data_rows && c < data_cols) begin
              sample_mem[r * MAX_DATA_COLS + c] = sample_value_i;
            end
          end
          OP_READ: conv_points_q.push_back(predict_read(r, c));
          default: ;
        endcase
      end

      pending_reads_o  <= conv_points_q.size();
      mismatch_count_o <= mismatch_count_o + errs;
    end
  end

endmodule

// ===== verif/tb_conv2d_full_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_full_matrix
// Stimulus and verdict for the full 2-D convolution block: directed corner
// items, then randomized load/read traffic over several size settings, with
// random gaps on the request side and random backpressure on the results.
// ----------------------------------------------------------------------------
module tb_conv2d_full_matrix;
  import conv2d_pkg::*;

  localparam int MaxDataRows   = 32;
  localparam int MaxDataCols   = 32;
  localparam int MaxKernelRows = 8;
  localparam int MaxKernelCols = 8;

  // settle time for the longest read, an 8x8 kernel walk plus the pipeline
  localparam int SettleCycles = 80;
  // covers the clearing pass after reset with a wide margin
  localparam int IdleLimit    = 5000;
  localparam int IdxMax       = (1 << IdxW) - 1;

  localparam logic [1:0]             OpUnused = 2'd3;
  localparam logic signed [ValW-1:0] QMin     = 16'sh8000;
  localparam logic signed [ValW-1:0] QMax     = 16'sh7FFF;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgW-1:0]        cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             op_i;
  logic [IdxW-1:0]        row_index_i;
  logic [IdxW-1:0]        col_index_i;
  logic signed [ValW-1:0] sample_value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [ResW-1:0] result_value_o;
  logic [1:0]             status_o;

  int unsigned pending_reads;
  int unsigned mismatch_count;

  // effective sizes, used only to aim stimulus at the interesting ranges
  int  drows_eff = 1;
  int  dcols_eff = 1;
  int  krows_eff = 1;
  int  kcols_eff = 1;
  bit  gaps_on   = 1'b1;
  int  idle_cycles;

  conv2d_full_matrix #(
    .MAX_DATA_ROWS  (MaxDataRows),
    .MAX_DATA_COLS  (MaxDataCols),
    .MAX_KERNEL_ROWS(MaxKernelRows),
    .MAX_KERNEL_COLS(MaxKernelCols)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

  conv2d_checker #(
    .MAX_DATA_ROWS  (MaxDataRows),
    .MAX_DATA_COLS  (MaxDataCols),
    .MAX_KERNEL_ROWS(MaxKernelRows),
    .MAX_KERNEL_COLS(MaxKernelCols)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .sample_value_i  (sample_value_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_i  (result_value_o),
    .status_i        (status_o),
    .pending_reads_o (pending_reads),
    .mismatch_count_o(mismatch_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Watchdog: any stretch with neither a request nor a result transfer that
  // runs past the limit means the block hung or lost a result.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("tb_conv2d_full_matrix NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side backpressure: runs of ready, mostly short, sometimes very
  // long (stall-free stretches); stalls mostly short with a few long ones.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int high_len;
    int low_len;
    int roll;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (high_len) @(posedge clk_i);
      roll = $urandom_range(0, 99);
      if (roll < 40)      low_len = 0;
      else if (roll < 85) low_len = $urandom_range(1, 4);
      else                low_len = $urandom_range(10, 60);
      if (low_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (low_len) @(posedge clk_i);
      end
    end
  end

  // 0 acts as 1, values above the maximum saturate
  function automatic int eff_size(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // mostly small sizes, now and then anything the register field can hold
  function automatic int pick_size_code(input int common_max);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, (1 << CfgW) - 1);
    return $urandom_range(1, common_max);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full-scale values show up often so sums reach their extremes
  function automatic logic signed [ValW-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return QMin;
    if (roll < 30) return QMax;
    if (roll < 35) return '0;
    return ValW'($urandom_range(0, (1 << ValW) - 1));
  endfunction

  // One request transfer. Called and returning on a rising edge; valid stays
  // high into the next item when no gap is drawn.
  task automatic send_item(input logic [1:0] op, input logic [IdxW-1:0] r,
                           input logic [IdxW-1:0] c, input logic signed [ValW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    row_index_i    <= r;
    col_index_i    <= c;
    sample_value_i <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Hold the request side until every predicted result has been taken.
  // The first edge lets the checker count a read accepted on the last one.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reads != 0);
  endtask

  // Loads leave no result behind, so also give a read in flight time to end.
  task automatic quiesce();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sizes(input logic [CfgW-1:0] dr, input logic [CfgW-1:0] dc,
                             input logic [CfgW-1:0] kr, input logic [CfgW-1:0] kc);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DATA_ROWS;
    cfg_data_i  <= dr;
    @(posedge clk_i);
    cfg_index_i <= REG_DATA_COLS;
    cfg_data_i  <= dc;
    @(posedge clk_i);
    cfg_index_i <= REG_KERNEL_ROWS;
    cfg_data_i  <= kr;
    @(posedge clk_i);
    cfg_index_i <= REG_KERNEL_COLS;
    cfg_data_i  <= kc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    drows_eff = eff_size(int'(dr[DSizeW-1:0]), MaxDataRows);
    dcols_eff = eff_size(int'(dc[DSizeW-1:0]), MaxDataCols);
    krows_eff = eff_size(int'(kr[KSizeW-1:0]), MaxKernelRows);
    kcols_eff = eff_size(int'(kc[KSizeW-1:0]), MaxKernelCols);
  endtask

  // Mostly in-range loads and reads; the rest lands anywhere in the index
  // space (ignored loads, out-of-range reads) plus the odd unused op code.
  // counted is low for items the block just drops.
  task automatic random_item(output bit counted);
    int              roll;
    bit              aimed;
    logic [1:0]      op;
    logic [IdxW-1:0] r, c;
    roll  = $urandom_range(0, 99);
    aimed = ($urandom_range(0, 99) < 85);
    r     = IdxW'($urandom_range(0, IdxMax));
    c     = IdxW'($urandom_range(0, IdxMax));
    if (roll < 30) begin
      op = OP_LOAD_KERNEL;
      if (aimed) begin
        r = IdxW'($urandom_range(0, krows_eff - 1));
        c = IdxW'($urandom_range(0, kcols_eff - 1));
      end
      counted = (r < krows_eff) && (c < kcols_eff);
    end else if (roll < 65) begin
      op = OP_LOAD_DATA;
      if (aimed) begin
        r = IdxW'($urandom_range(0, drows_eff - 1));
        c = IdxW'($urandom_range(0, dcols_eff - 1));
      end
      counted = (r < drows_eff) && (c < dcols_eff);
    end else if (roll < 95) begin
      op = OP_READ;
      if (aimed) begin
        r = IdxW'($urandom_range(0, drows_eff + krows_eff - 2));
        c = IdxW'($urandom_range(0, dcols_eff + kcols_eff - 2));
      end
      counted = 1'b1;
    end else begin
      op      = OpUnused;
      counted = 1'b0;
    end
    send_item(op, r, c, pick_sample());
  endtask

  // After the first twenty items of each phase the sender pauses for a full drain.
  task automatic run_random(input int budget, input bit with_gaps);
    int done;
    int iter;
    bit counted;
    gaps_on = with_gaps;
    done    = 0;
    iter    = 0;
    while (done < budget) begin
      if (iter == 20) drain_results();
      random_item(counted);
      if (counted) done++;
      iter++;
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    in_valid_i     = 1'b0;
    op_i           = OP_LOAD_KERNEL;
    row_index_i    = '0;
    col_index_i    = '0;
    sample_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_DATA_ROWS;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sizes at reset: 1x1 data, 1x1 kernel, so the output is a single point.
    // Nothing loaded yet: in-range read reports the missing kernel, reads
    // past the output report range first.
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OP_READ, IdxW'(IdxMax), IdxW'(IdxMax), QMax);
    send_item(OP_READ, 6'd0, 6'd1, '0);
    // kernel loads outside the size are dropped and must not arm the kernel
    send_item(OP_LOAD_KERNEL, 6'd1, 6'd0, QMax);
    send_item(OP_LOAD_KERNEL, 6'd0, IdxW'(IdxMax), QMin);
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OpUnused, IdxW'(IdxMax), IdxW'(IdxMax), '1);
    send_item(OP_LOAD_DATA, 6'd0, 6'd0, QMin);
    send_item(OP_LOAD_DATA, 6'd5, 6'd0, 16'sd1234);
    send_item(OP_LOAD_KERNEL, 6'd0, 6'd0, QMin);
    // most negative squared: the largest single product
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OP_LOAD_KERNEL, 6'd0, 6'd0, QMax);
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OP_LOAD_DATA, 6'd0, 6'd0, QMax);
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OP_READ, 6'd1, 6'd1, '0);

    // Over-range codes saturate: 63 rows -> 32, 15 kernel rows -> 8.
    quiesce();
    write_sizes(6'd63, 6'd32, 6'd15, 6'd8);
    send_item(OP_LOAD_KERNEL, 6'd7, 6'd7, QMin);
    send_item(OP_LOAD_DATA, 6'd31, 6'd31, QMin);
    // far corner of the 39x39 output
    send_item(OP_READ, 6'd38, 6'd38, '0);
    send_item(OP_READ, 6'd39, 6'd0, '0);
    send_item(OP_READ, 6'd0, 6'd39, '0);
    // stores survive the resize
    send_item(OP_READ, 6'd0, 6'd0, '0);
    send_item(OP_READ, 6'd7, 6'd7, '0);
    run_random(130, 1'b1);

    // zero codes act as 1; kernel stays armed
    quiesce();
    write_sizes('0, '0, '0, '0);
    run_random(35, 1'b0);

    for (k = 0; k < 5; k++) begin
      quiesce();
      write_sizes(CfgW'(pick_size_code(8)), CfgW'(pick_size_code(8)),
                  CfgW'(pick_size_code(4)), CfgW'(pick_size_code(4)));
      run_random(90, k[0]);
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("tb_conv2d_full_matrix OK");
    end else begin
      $display("tb_conv2d_full_matrix NOT OK");
    end
    $finish;
  end

endmodule
